// ===== design/stall_detect_endstop_calibrator_macros.svh =====
// Assertion macros for the checker file of the calibrator.
`ifndef STALL_DETECT_ENDSTOP_CALIBRATOR_MACROS_SVH
`define STALL_DETECT_ENDSTOP_CALIBRATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibrator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibrator assertion failed");

`endif

// ===== design/sdec_pkg.sv =====
package sdec_pkg;

    localparam int WIN_LEN   = 16;
    localparam int PTR_W     = $clog2(WIN_LEN);
    localparam int MAG_W     = 16;
    localparam int SUM_W     = MAG_W + PTR_W;
    localparam int VEL_W     = 16;
    localparam int POS_W     = 32;
    localparam int CMD_W     = 16;
    localparam int CUR_W     = 15;
    localparam int DLY_W     = 16;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [CUR_W-1:0] DRIVE_CURRENT_RST   = CUR_W'(1000);
    localparam logic             UP_IS_POSITIVE_RST  = 1'b1;
    localparam logic [DLY_W-1:0] STARTUP_DELAY_RST   = DLY_W'(100);
    localparam logic [THR_W-1:0] STALL_THRESHOLD_RST = THR_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_CURRENT   = CFG_IDX_W'(0),
        CFG_UP_IS_POSITIVE  = CFG_IDX_W'(1),
        CFG_STARTUP_DELAY   = CFG_IDX_W'(2),
        CFG_STALL_THRESHOLD = CFG_IDX_W'(3)
    } cfg_idx_t;

    typedef struct packed {
        logic [CUR_W-1:0] drive_current;
        logic             up_is_positive;
        logic [DLY_W-1:0] startup_delay;
        logic [THR_W-1:0] stall_threshold;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic clear;
    } win_ctrl_t;

endpackage

// ===== design/sdec_cfg.sv =====
module sdec_cfg
    import sdec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_current   <= DRIVE_CURRENT_RST;
            cfg_reg.up_is_positive  <= UP_IS_POSITIVE_RST;
            cfg_reg.startup_delay   <= STARTUP_DELAY_RST;
            cfg_reg.stall_threshold <= STALL_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DRIVE_CURRENT:   cfg_reg.drive_current   <= cfg_data[CUR_W-1:0];
                CFG_UP_IS_POSITIVE:  cfg_reg.up_is_positive  <= cfg_data[0];
                CFG_STARTUP_DELAY:   cfg_reg.startup_delay   <= cfg_data[DLY_W-1:0];
                CFG_STALL_THRESHOLD: cfg_reg.stall_threshold <= cfg_data[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/sdec_window.sv =====
module sdec_window
    import sdec_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [DLY_W-1:0]        startup_delay,
    input  logic [THR_W-1:0]        stall_threshold,
    input  logic signed [VEL_W-1:0] velocity,
    input  win_ctrl_t               ctrl,
    output logic                    stall
);

    logic [MAG_W-1:0] window_reg [WIN_LEN];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [DLY_W-1:0] delay_reg;
    logic [MAG_W-1:0] mag;
    logic [SUM_W-1:0] thr_scaled;
    logic             delay_ok;

    // The absolute value of the most negative velocity fits as an unsigned entry.
    assign mag        = velocity[VEL_W-1] ? MAG_W'(-velocity) : MAG_W'(velocity);
    assign sum_next   = sum_reg - SUM_W'(window_reg[ptr_reg]) + SUM_W'(mag);
    assign ptr_next   = (ptr_reg == PTR_W'(WIN_LEN - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign thr_scaled = SUM_W'(stall_threshold) * SUM_W'(WIN_LEN);
    assign delay_ok   = (delay_reg >= startup_delay);
    assign stall      = delay_ok && (sum_next <= thr_scaled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            sum_reg   <= '0;
            delay_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            sum_reg   <= '0;
            delay_reg <= '0;
        end
        else if (ctrl.push)
        begin
            window_reg[ptr_reg] <= mag;
            ptr_reg             <= ptr_next;
            sum_reg             <= sum_next;
            if (!delay_ok)
            begin
                delay_reg <= delay_reg + DLY_W'(1);
            end
        end
    end

endmodule

// ===== design/stall_detect_endstop_calibrator.sv =====
// The calibrator takes one item per control tick and returns one result item for each,
// at a sustained rate of one item per clock cycle while the output is not stalled. A
// result is presented after its item passes the input register, then the result register;
// the running window sum is updated as the item enters the result register. While a
// result is held off, one item waits in the input register and the input stalls. It first
// drives the joint toward the low end, then toward the high end, declaring an end found
// when the limit key is pressed or, once the start-up delay has passed, when the average
// absolute velocity over a sixteen-entry window is at or below the stall threshold. The
// window is cleared at each capture and its empty entries count as zero. Captured
// positions read as zero until their end is done.
// Write configuration only while no item is in flight; the block does not enforce it.
module stall_detect_endstop_calibrator
    import sdec_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VEL_W-1:0] velocity,
    input  logic signed [POS_W-1:0] position,
    input  logic                    key_low,
    input  logic                    key_high,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [CMD_W-1:0] drive_command,
    output logic                    low_done,
    output logic                    high_done,
    output logic signed [POS_W-1:0] low_position,
    output logic signed [POS_W-1:0] high_position
);

    cfg_t      cfg;
    win_ctrl_t win_ctrl;
    logic      stall;

    logic                    in_valid_reg;
    logic signed [VEL_W-1:0] velocity_reg;
    logic signed [POS_W-1:0] position_reg;
    logic                    key_low_reg;
    logic                    key_high_reg;

    logic                    low_done_reg;
    logic                    low_done_next;
    logic                    high_done_reg;
    logic                    high_done_next;
    logic signed [POS_W-1:0] low_capture_reg;
    logic signed [POS_W-1:0] low_capture_next;
    logic signed [POS_W-1:0] high_capture_reg;
    logic signed [POS_W-1:0] high_capture_next;

    logic                    out_valid_reg;
    logic signed [CMD_W-1:0] cmd_reg;
    logic signed [CMD_W-1:0] cmd_next;
    logic                    out_low_done_reg;
    logic                    out_high_done_reg;
    logic signed [POS_W-1:0] out_low_pos_reg;
    logic signed [POS_W-1:0] out_high_pos_reg;

    logic                    advance;
    logic                    fire;
    logic                    seek_low;
    logic                    seek_high;
    logic                    seeking;
    logic                    key_hit;
    logic                    capture;
    logic                    cmd_positive;
    logic signed [CMD_W-1:0] pos_cmd;

    sdec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdec_window u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .startup_delay   (cfg.startup_delay),
        .stall_threshold (cfg.stall_threshold),
        .velocity        (velocity_reg),
        .ctrl            (win_ctrl),
        .stall           (stall)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign seek_low     = !low_done_reg;
    assign seek_high    = low_done_reg && !high_done_reg;
    assign seeking      = seek_low || seek_high;
    assign key_hit      = seek_low ? key_low_reg : key_high_reg;
    assign capture      = seeking && (key_hit || stall);
    assign cmd_positive = (seek_high == cfg.up_is_positive);
    assign pos_cmd      = CMD_W'(cfg.drive_current);

    assign win_ctrl.push  = fire && seeking && !key_hit;
    assign win_ctrl.clear = fire && capture;

    always_comb
    begin
        low_done_next     = low_done_reg;
        high_done_next    = high_done_reg;
        low_capture_next  = low_capture_reg;
        high_capture_next = high_capture_reg;
        cmd_next          = '0;
        if (seeking && !capture)
        begin
            cmd_next = cmd_positive ? pos_cmd : -pos_cmd;
        end
        if (capture && seek_low)
        begin
            low_done_next    = 1'b1;
            low_capture_next = position_reg;
        end
        if (capture && seek_high)
        begin
            high_done_next    = 1'b1;
            high_capture_next = position_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            low_done_reg      <= 1'b0;
            high_done_reg     <= 1'b0;
            low_capture_reg   <= '0;
            high_capture_reg  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg    <= 1'b1;
                low_done_reg     <= low_done_next;
                high_done_reg    <= high_done_next;
                low_capture_reg  <= low_capture_next;
                high_capture_reg <= high_capture_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            velocity_reg <= velocity;
            position_reg <= position;
            key_low_reg  <= key_low;
            key_high_reg <= key_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg           <= '0;
            out_low_done_reg  <= 1'b0;
            out_high_done_reg <= 1'b0;
            out_low_pos_reg   <= '0;
            out_high_pos_reg  <= '0;
        end
        else if (fire)
        begin
            cmd_reg           <= cmd_next;
            out_low_done_reg  <= low_done_next;
            out_high_done_reg <= high_done_next;
            out_low_pos_reg   <= low_capture_next;
            out_high_pos_reg  <= high_capture_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_command = cmd_reg;
    assign low_done      = out_low_done_reg;
    assign high_done     = out_high_done_reg;
    assign low_position  = out_low_pos_reg;
    assign high_position = out_high_pos_reg;

endmodule

// ===== design/sdec_checker.sv =====
`include "stall_detect_endstop_calibrator_macros.svh"

module sdec_checker
    import sdec_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [CMD_W-1:0] drive_command,
    input logic                    low_done,
    input logic                    high_done,
    input logic signed [POS_W-1:0] low_position
);

    // Once the low end is captured it stays captured.
    `SDEC_ASSERT_NEXT(a_low_done_holds, clk, rst_n, low_done, low_done)

    // The high end is only sought after the low end.
    `SDEC_ASSERT_SAME(a_high_after_low, clk, rst_n, high_done, low_done)

    // A captured low position never moves afterwards.
    `SDEC_ASSERT_NEXT(a_low_pos_stable, clk, rst_n, low_done, $stable(low_position))

    // With both ends found the motor is never driven.
    `SDEC_ASSERT_SAME(a_idle_no_drive, clk, rst_n, out_valid && high_done,
        drive_command == '0)

    // A stalled result item keeps its command.
    `SDEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(drive_command))

endmodule

bind stall_detect_endstop_calibrator sdec_checker u_sdec_checker (.*);
